@@ sv/epe_pkg.sv @@
// ============================================================================
// epe_pkg: shared types and constants of the encoder PLL phase estimator
// Sequencer states, serial unit widths, status struct and register indexes.
// ============================================================================
`default_nettype none

package epe_pkg;

  // Fixed-point layout
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned CNT_W     = 16;   // raw timer counter width
  localparam int unsigned POS_W     = 48;   // Q32.16 position and velocity
  localparam int unsigned INTERP_W  = FRAC_BITS + 1;

  localparam logic [INTERP_W-1:0] ONE_Q  = INTERP_W'(1) << FRAC_BITS;
  localparam logic [INTERP_W-1:0] HALF_Q = INTERP_W'(1) << (FRAC_BITS - 1);

  // Serial multiplier: signed A times unsigned B, one bit of B per cycle
  localparam int unsigned MUL_AW  = 49;
  localparam int unsigned MUL_BW  = 64;
  localparam int unsigned MUL_PW  = MUL_AW + MUL_BW;
  localparam int unsigned MUL_CW  = $clog2(MUL_BW);

  // Serial divider: signed numerator, unsigned divisor, floor quotient
  localparam int unsigned DIV_NW  = 57;
  localparam int unsigned DIV_MW  = DIV_NW - 1;
  localparam int unsigned DIV_DW  = 32;
  localparam int unsigned DIV_CW  = $clog2(DIV_MW);

  // Configuration register indexes
  localparam int unsigned CFG_AW = 3;
  localparam logic [CFG_AW-1:0] REG_CPR    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_POLES  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_OFFSET = 3'd2;
  localparam logic [CFG_AW-1:0] REG_FINE   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_BW     = 3'd4;
  localparam logic [CFG_AW-1:0] REG_DT     = 3'd5;
  localparam logic [CFG_AW-1:0] REG_INTERP = 3'd6;
  localparam logic [CFG_AW-1:0] REG_ENABLE = 3'd7;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Tick sequencer: M_* starts a multiply, D_* a divide, W_* captures
  typedef enum logic [5:0] {
    S_IDLE,
    S_M_BW2,   S_W_BW2,
    S_M_BWDT,  S_W_BWDT,
    S_M_KIDT,  S_W_KIDT,
    S_D_RC,    S_W_RC,
    S_M_DV,    S_W_DV,
    S_D_DCPR,  S_W_DCPR,
    S_M_KPPOS, S_W_KPPOS,
    S_M_KPREV, S_W_KPREV,
    S_D_REV,   S_W_REV,
    S_M_KIVEL, S_W_KIVEL,
    S_DEADB,
    S_M_INT,   S_W_INT,
    S_D_OFF,   S_W_OFF,
    S_D_CORR,  S_W_CORR,
    S_M_EPP,   S_W_EPP,
    S_D_E,     S_W_E,
    S_D_PH,    S_W_PH,
    S_D_VQ,    S_W_VQ,
    S_M_QPP,   S_W_QPP,
    S_M_RPP,   S_W_RPP,
    S_D_EV,    S_W_EV,
    S_OUT
  } seq_state_e;

endpackage

`default_nettype wire

@@ sv/epe_mul.sv @@
// ============================================================================
// epe_mul: radix-2 serial multiplier
// Signed A times unsigned B; B shifts out of the accumulator one bit a cycle.
// ============================================================================
`default_nettype none

module epe_mul (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [epe_pkg::MUL_AW-1:0]    a_i,
  input  wire logic [epe_pkg::MUL_BW-1:0]    b_i,
  output epe_pkg::unit_stat_t                stat_o,
  output logic      [epe_pkg::MUL_PW-1:0]    p_o
);
  import epe_pkg::*;

  logic [MUL_PW-1:0] acc_q, acc_d;
  logic [MUL_AW-1:0] a_q;
  logic [MUL_CW-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [MUL_AW:0]   sum;

  // one add of A into the upper half, then shift right
  always_comb begin
    sum   = {acc_q[MUL_PW-1], acc_q[MUL_PW-1:MUL_BW]} +
            (acc_q[0] ? {a_q[MUL_AW-1], a_q} : {(MUL_AW+1){1'b0}});
    acc_d = {sum, acc_q[MUL_BW-1:1]};
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + MUL_CW'(1);
        if (cnt_q == MUL_CW'(MUL_BW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      acc_q <= {{MUL_AW{1'b0}}, b_i};
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign p_o         = acc_q;

endmodule

`default_nettype wire

@@ sv/epe_div.sv @@
// ============================================================================
// epe_div: restoring serial divider with floor rounding
// One quotient bit per cycle on the magnitude, then a sign fix-up step.
// ============================================================================
`default_nettype none

module epe_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [epe_pkg::DIV_NW-1:0]    num_i,
  input  wire logic [epe_pkg::DIV_DW-1:0]    den_i,
  output epe_pkg::unit_stat_t                stat_o,
  output logic      [epe_pkg::DIV_NW-1:0]    quot_o,
  output logic      [epe_pkg::DIV_DW-1:0]    rem_o
);
  import epe_pkg::*;

  logic [DIV_MW-1:0] dvd_q;
  logic [DIV_DW-1:0] rem_q, den_q, rem_out_q;
  logic [DIV_NW-1:0] quot_out_q, num_abs;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q, fix_q, done_q, neg_q;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  assign num_abs = num_i[DIV_NW-1] ? (DIV_NW'(0) - num_i) : num_i;

  // trial subtract
  always_comb begin
    trial = {rem_q, dvd_q[DIV_MW-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (fix_q) begin
        fix_q  <= 1'b0;
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CW'(1);
        if (cnt_q == DIV_CW'(DIV_MW - 1)) fix_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[DIV_NW-1];
      dvd_q <= num_abs[DIV_MW-1:0];
      rem_q <= '0;
      den_q <= den_i;
    end else if (fix_q) begin
      // floor correction for a negative numerator
      if (neg_q && (rem_q != '0)) begin
        quot_out_q <= ~{1'b0, dvd_q};
        rem_out_q  <= den_q - rem_q;
      end else if (neg_q) begin
        quot_out_q <= DIV_NW'(0) - {1'b0, dvd_q};
        rem_out_q  <= '0;
      end else begin
        quot_out_q <= {1'b0, dvd_q};
        rem_out_q  <= rem_q;
      end
    end else if (busy_q) begin
      rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      dvd_q <= {dvd_q[DIV_MW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_out_q;
  assign rem_o       = rem_out_q;

endmodule

`default_nettype wire

@@ sv/encoder_pll_phase_estimator_core.sv @@
// ============================================================================
// encoder_pll_phase_estimator_core: quadrature encoder PLL estimator
// Count extension, second-order PLL, interpolation and electrical phase.
// ============================================================================
// Each timer sample request yields one result request. In an enabled tick a
// sequencer runs eleven products through one serial multiplier (one bit of
// the multiplier operand per cycle) and nine floor divisions through one
// serial divider, the interpolation product only when the velocity is
// outside the deadband, interpolation is enabled and no edge was seen. A
// disabled tick goes from idle straight to the output state and returns the
// held estimator state with zero phase and electrical velocity. A new sample
// is taken once the previous one has left the sequencer; a finished result
// waits in the output register meanwhile. Configuration writes are accepted
// every cycle and must be issued while the block is idle.
`default_nettype none

module encoder_pll_phase_estimator_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // timer samples: [15:0] timer_count
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  wire logic [15:0]                 s_axis_tdata_i,
  // results: [31:0] position_count, [47:32] count_in_rev,
  // [95:48] position_estimate, [127:96] rev_position_estimate,
  // [175:128] velocity_estimate, [192:176] interpolation,
  // [208:193] electrical_phase, [256:209] electrical_velocity, rest zero
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  output logic [263:0]                     m_axis_tdata_o,
  // [0] updated
  output logic [0:0]                       m_axis_tuser_o,
  // configuration writes
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [epe_pkg::CFG_AW-1:0]  cfg_addr_i,
  input  wire logic [31:0]                 cfg_data_i
);
  import epe_pkg::*;

  // configuration
  logic [15:0] cpr_q, off_q, bw_q;
  logic [7:0]  pp_q;
  logic [16:0] fine_q;
  logic [31:0] dt_q;
  logic        interp_en_q, en_q;

  // estimator state
  logic [31:0]         wide_q, revp_q;
  logic [15:0]         rev_cnt_q;
  logic [POS_W-1:0]    pos_q, vel_q;
  logic [INTERP_W-1:0] interp_q;

  // per-tick scratch
  seq_state_e  state_q, state_d;
  logic        upd_q;
  logic [15:0] delta_q, offm_q, rr_q;
  logic [31:0] bw2_q, c_q, e_q;
  logic [48:0] kpdt_q;
  logic [63:0] kidt_q;
  logic [52:0] revt_q;
  logic [16:0] dcpr_q;
  logic [15:0] phase_q;
  logic [47:0] qv_q, evel_q;
  logic [56:0] t_q;

  // output register
  logic         out_valid_q;
  logic [263:0] out_data_q;
  logic         out_user_q;

  // serial units
  logic              mul_start, div_start;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;
  unit_stat_t        mul_stat, div_stat;
  logic [DIV_NW-1:0] div_num, div_quot;
  logic [DIV_DW-1:0] div_den, div_rem;

  epe_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .stat_o  (mul_stat),
    .p_o     (mul_p)
  );

  epe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .stat_o  (div_stat),
    .quot_o  (div_quot),
    .rem_o   (div_rem)
  );

  // derived values
  logic [15:0] cpr_eff, delta_in;
  logic [31:0] mod_m, dpos;
  logic        in_req, out_free;
  logic [17:0] rc_num;
  logic [47:0] thr, vel_abs;
  logic        db_zero, need_int;
  logic [15:0] dcpr_r;
  logic [16:0] dcpr_fix;
  logic [97:0] ki_sum;
  logic [47:0] vel_ki;
  logic [49:0] int_sum;
  logic [16:0] int_clamp;
  logic [73:0] ev_sum;
  logic [47:0] ev_sat;

  assign cpr_eff  = (cpr_q == '0) ? 16'd1 : cpr_q;
  assign mod_m    = {cpr_eff, 16'b0};
  assign delta_in = s_axis_tdata_i - wide_q[15:0];
  assign in_req   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign rc_num   = {2'b00, rev_cnt_q} + {{2{delta_q[15]}}, delta_q};
  assign dpos     = wide_q - pos_q[47:16];

  // wrap of the revolution error into [-cpr/2, cpr/2)
  assign dcpr_r   = div_rem[15:0];
  assign dcpr_fix = ({dcpr_r, 1'b0} >= {1'b0, cpr_eff}) ?
                    ({1'b0, dcpr_r} - {1'b0, cpr_eff}) : {1'b0, dcpr_r};

  // integral path with saturation to 48 bits
  always_comb begin
    ki_sum = {{50{vel_q[47]}}, vel_q} + {mul_p[MUL_PW-1], mul_p[MUL_PW-1:16]};
    if (ki_sum[97:47] == {51{ki_sum[97]}}) vel_ki = ki_sum[47:0];
    else vel_ki = ki_sum[97] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
  end

  // deadband: |vel| below ceil(kidt / 2^17)
  always_comb begin
    thr      = {1'b0, kidt_q[63:17]} + 48'(|kidt_q[16:0]);
    vel_abs  = vel_q[47] ? (48'd0 - vel_q) : vel_q;
    db_zero  = (vel_abs < thr);
    need_int = !db_zero && interp_en_q && (delta_q == '0);
  end

  // interpolation advance, clamped to [0, one]
  always_comb begin
    int_sum = {33'b0, interp_q} + {{2{mul_p[79]}}, mul_p[79:32]};
    if (int_sum[49]) int_clamp = '0;
    else if (int_sum > 50'(ONE_Q)) int_clamp = ONE_Q;
    else int_clamp = int_sum[16:0];
  end

  // electrical velocity sum with saturation
  always_comb begin
    ev_sum = {t_q[56], t_q, 16'b0} + {50'b0, div_quot[23:0]};
    if (ev_sum[73:47] == {27{ev_sum[73]}}) ev_sat = ev_sum[47:0];
    else ev_sat = ev_sum[73] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_req) state_d = en_q ? S_M_BW2 : S_OUT;
      S_M_BW2:   state_d = S_W_BW2;
      S_W_BW2:   if (mul_stat.done) state_d = S_M_BWDT;
      S_M_BWDT:  state_d = S_W_BWDT;
      S_W_BWDT:  if (mul_stat.done) state_d = S_M_KIDT;
      S_M_KIDT:  state_d = S_W_KIDT;
      S_W_KIDT:  if (mul_stat.done) state_d = S_D_RC;
      S_D_RC:    state_d = S_W_RC;
      S_W_RC:    if (div_stat.done) state_d = S_M_DV;
      S_M_DV:    state_d = S_W_DV;
      S_W_DV:    if (mul_stat.done) state_d = S_D_DCPR;
      S_D_DCPR:  state_d = S_W_DCPR;
      S_W_DCPR:  if (div_stat.done) state_d = S_M_KPPOS;
      S_M_KPPOS: state_d = S_W_KPPOS;
      S_W_KPPOS: if (mul_stat.done) state_d = S_M_KPREV;
      S_M_KPREV: state_d = S_W_KPREV;
      S_W_KPREV: if (mul_stat.done) state_d = S_D_REV;
      S_D_REV:   state_d = S_W_REV;
      S_W_REV:   if (div_stat.done) state_d = S_M_KIVEL;
      S_M_KIVEL: state_d = S_W_KIVEL;
      S_W_KIVEL: if (mul_stat.done) state_d = S_DEADB;
      S_DEADB:   state_d = need_int ? S_M_INT : S_D_OFF;
      S_M_INT:   state_d = S_W_INT;
      S_W_INT:   if (mul_stat.done) state_d = S_D_OFF;
      S_D_OFF:   state_d = S_W_OFF;
      S_W_OFF:   if (div_stat.done) state_d = S_D_CORR;
      S_D_CORR:  state_d = S_W_CORR;
      S_W_CORR:  if (div_stat.done) state_d = S_M_EPP;
      S_M_EPP:   state_d = S_W_EPP;
      S_W_EPP:   if (mul_stat.done) state_d = S_D_E;
      S_D_E:     state_d = S_W_E;
      S_W_E:     if (div_stat.done) state_d = S_D_PH;
      S_D_PH:    state_d = S_W_PH;
      S_W_PH:    if (div_stat.done) state_d = S_D_VQ;
      S_D_VQ:    state_d = S_W_VQ;
      S_W_VQ:    if (div_stat.done) state_d = S_M_QPP;
      S_M_QPP:   state_d = S_W_QPP;
      S_W_QPP:   if (mul_stat.done) state_d = S_M_RPP;
      S_M_RPP:   state_d = S_W_RPP;
      S_W_RPP:   if (mul_stat.done) state_d = S_D_EV;
      S_D_EV:    state_d = S_W_EV;
      S_W_EV:    if (div_stat.done) state_d = S_OUT;
      S_OUT:     if (out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // unit requests and operand selection
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = {16'b0, cpr_eff};
    case (state_q)
      S_M_BW2: begin
        mul_start = 1'b1;
        mul_a = {33'b0, bw_q};
        mul_b = {48'b0, bw_q};
      end
      S_M_BWDT: begin
        mul_start = 1'b1;
        mul_a = {33'b0, bw_q};
        mul_b = {32'b0, dt_q};
      end
      S_M_KIDT: begin
        mul_start = 1'b1;
        mul_a = {17'b0, bw2_q};
        mul_b = {32'b0, dt_q};
      end
      S_D_RC: begin
        div_start = 1'b1;
        div_num = {{39{rc_num[17]}}, rc_num};
      end
      S_M_DV, S_M_INT: begin
        mul_start = 1'b1;
        mul_a = {vel_q[47], vel_q};
        mul_b = {32'b0, dt_q};
      end
      S_D_DCPR: begin
        div_start = 1'b1;
        div_num = {41'b0, rev_cnt_q} - {{20{revt_q[52]}}, revt_q[52:16]};
      end
      S_M_KPPOS: begin
        mul_start = 1'b1;
        mul_a = {{17{dpos[31]}}, dpos};
        mul_b = {15'b0, kpdt_q};
      end
      S_M_KPREV: begin
        mul_start = 1'b1;
        mul_a = {{32{dcpr_q[16]}}, dcpr_q};
        mul_b = {15'b0, kpdt_q};
      end
      S_D_REV: begin
        div_start = 1'b1;
        div_num = {{4{revt_q[52]}}, revt_q};
        div_den = mod_m;
      end
      S_M_KIVEL: begin
        mul_start = 1'b1;
        mul_a = {{32{dcpr_q[16]}}, dcpr_q};
        mul_b = kidt_q;
      end
      S_D_OFF: begin
        div_start = 1'b1;
        div_num = {41'b0, off_q};
      end
      S_D_CORR: begin
        div_start = 1'b1;
        div_num = {25'b0, rev_cnt_q, 16'b0} - {25'b0, offm_q, 16'b0} +
                  {40'b0, interp_q} - {{40{fine_q[16]}}, fine_q};
        div_den = mod_m;
      end
      S_M_EPP: begin
        mul_start = 1'b1;
        mul_a = {17'b0, c_q};
        mul_b = {56'b0, pp_q};
      end
      S_D_E: begin
        div_start = 1'b1;
        div_num = {17'b0, mul_p[39:0]};
        div_den = mod_m;
      end
      S_D_PH: begin
        div_start = 1'b1;
        div_num = {9'b0, e_q, 16'b0};
        div_den = mod_m;
      end
      S_D_VQ: begin
        div_start = 1'b1;
        div_num = {{9{vel_q[47]}}, vel_q};
      end
      S_M_QPP: begin
        mul_start = 1'b1;
        mul_a = {qv_q[47], qv_q};
        mul_b = {56'b0, pp_q};
      end
      S_M_RPP: begin
        mul_start = 1'b1;
        mul_a = {33'b0, rr_q};
        mul_b = {56'b0, pp_q};
      end
      S_D_EV: begin
        div_start = 1'b1;
        div_num = {17'b0, mul_p[23:0], 16'b0};
      end
      default: begin
        mul_start = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpr_q       <= 16'd8192;
      pp_q        <= 8'd7;
      off_q       <= '0;
      fine_q      <= '0;
      bw_q        <= 16'd1000;
      dt_q        <= 32'd536871;
      interp_en_q <= 1'b1;
      en_q        <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_addr_i)
        REG_CPR:    cpr_q       <= cfg_data_i[15:0];
        REG_POLES:  pp_q        <= cfg_data_i[7:0];
        REG_OFFSET: off_q       <= cfg_data_i[15:0];
        REG_FINE:   fine_q      <= cfg_data_i[16:0];
        REG_BW:     bw_q        <= cfg_data_i[15:0];
        REG_DT:     dt_q        <= cfg_data_i;
        REG_INTERP: interp_en_q <= cfg_data_i[0];
        REG_ENABLE: en_q        <= cfg_data_i[0];
        default:    en_q        <= en_q;
      endcase
    end
  end

  // estimator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q    <= '0;
      rev_cnt_q <= '0;
      pos_q     <= '0;
      revp_q    <= '0;
      vel_q     <= '0;
      interp_q  <= HALF_Q;
    end else begin
      case (state_q)
        S_IDLE:
          if (in_req && en_q) wide_q <= wide_q + {{16{delta_in[15]}}, delta_in};
        S_W_RC:    if (div_stat.done) rev_cnt_q <= div_rem[15:0];
        S_W_DV:    if (mul_stat.done) pos_q <= pos_q + mul_p[79:32];
        S_W_KPPOS: if (mul_stat.done) pos_q <= pos_q + mul_p[63:16];
        S_W_REV:   if (div_stat.done) revp_q <= div_rem;
        S_W_KIVEL: if (mul_stat.done) vel_q <= vel_ki;
        S_DEADB: begin
          if (db_zero) begin
            vel_q    <= '0;
            interp_q <= HALF_Q;
          end else if (!interp_en_q) begin
            interp_q <= HALF_Q;
          end else if (!delta_q[15] && delta_q != '0) begin
            interp_q <= '0;
          end else if (delta_q[15]) begin
            interp_q <= ONE_Q;
          end
        end
        S_W_INT:   if (mul_stat.done) interp_q <= int_clamp;
        default:   wide_q <= wide_q;
      endcase
    end
  end

  // per-tick scratch registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_req) begin
          delta_q <= delta_in;
          upd_q   <= en_q;
          phase_q <= '0;
          evel_q  <= '0;
        end
      end
      S_W_BW2:   if (mul_stat.done) bw2_q  <= mul_p[31:0];
      S_W_BWDT:  if (mul_stat.done) kpdt_q <= {mul_p[47:0], 1'b0};
      S_W_KIDT:  if (mul_stat.done) kidt_q <= mul_p[63:0];
      S_W_DV:
        if (mul_stat.done) revt_q <= {21'b0, revp_q} + {{5{mul_p[79]}}, mul_p[79:32]};
      S_W_DCPR:  if (div_stat.done) dcpr_q <= dcpr_fix;
      S_W_KPREV:
        if (mul_stat.done) revt_q <= revt_q + {{3{mul_p[65]}}, mul_p[65:16]};
      S_W_OFF:   if (div_stat.done) offm_q <= div_rem[15:0];
      S_W_CORR:  if (div_stat.done) c_q <= div_rem;
      S_W_E:     if (div_stat.done) e_q <= div_rem;
      S_W_PH:    if (div_stat.done) phase_q <= div_quot[15:0];
      S_W_VQ: begin
        if (div_stat.done) begin
          qv_q <= div_quot[47:0];
          rr_q <= div_rem[15:0];
        end
      end
      S_W_QPP:   if (mul_stat.done) t_q <= mul_p[56:0];
      S_W_EV:    if (div_stat.done) evel_q <= ev_sat;
      default:   upd_q <= upd_q;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      out_user_q <= upd_q;
      out_data_q <= {7'b0, evel_q, phase_q, interp_q, vel_q, revp_q, pos_q,
                     rev_cnt_q, wide_q};
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign cfg_ready_o     = 1'b1;

  // checks
  a_mul_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_stat.busy)
    else $error("multiplier started while busy");

  a_div_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_OUT))
    else $error("result shown without a finished tick");

  a_interp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    interp_q <= ONE_Q)
    else $error("interpolation above one");

endmodule

`default_nettype wire
